[design/fetoc_pkg.sv]
// ----------------------------------------------------------------------------
// Free extent table package
// Shared types, codes and default sizes of the free extent table.
// ----------------------------------------------------------------------------
package fetoc_pkg;

   localparam int DEFAULT_MAX_FILES   = 16;
   localparam int DEFAULT_MAX_EXTENTS = 64;

   localparam int KEY_W    = 56;
   localparam int OFFSET_W = 31;
   localparam int ENTRY_W  = 2 * OFFSET_W;
   localparam int FILES_W  = 5;
   localparam int TOTAL_W  = 11;

   typedef enum logic [1:0] {
      OP_CHECK  = 2'd0,
      OP_INSERT = 2'd1,
      OP_DELETE = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_DUP        = 3'd1,
      ST_OVERLAP    = 3'd2,
      ST_NOT_FOUND  = 3'd3,
      ST_FILES_FULL = 3'd4,
      ST_LIST_FULL  = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_SCAN,
      CMD_SETUP,
      CMD_RD_FIRST,
      CMD_RD_LAST,
      CMD_RD_MID,
      CMD_RD_POS,
      CMD_BS_STEP,
      CMD_K_POS,
      CMD_UP_RD,
      CMD_UP_WR,
      CMD_DN_RD,
      CMD_DN_WR,
      CMD_INS,
      CMD_DEL
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic       result;
      status_type code;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       scan_done;
      logic       hit;
      logic       free_ok;
      logic       count_zero;
      logic       list_full;
      logic       lo_lt_hi;
      logic       pos_lt_n;
      logic       k_gt_pos;
      logic       k1_lt_n;
      logic       e_le_st;
      logic       s_ge_end;
      logic       s_lt_st;
      logic       s_eq_st;
      logic       len_eq;
      logic       st_lt_e;
      logic       s_lt_end;
   } dp_status_type;

endpackage

[design/fetoc_req_if.sv]
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one request word.
// ----------------------------------------------------------------------------
interface fetoc_req_if import fetoc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [1:0]          operation;
   logic [7:0]          store_index;
   logic [7:0]          dir_high;
   logic [7:0]          dir_low;
   logic [31:0]         trunk_id;
   logic [OFFSET_W-1:0] extent_start;
   logic [OFFSET_W-1:0] extent_length;

   modport source (output valid, operation, store_index, dir_high, dir_low, trunk_id,
                   extent_start, extent_length, input ready);
   modport sink   (input valid, operation, store_index, dir_high, dir_low, trunk_id,
                   extent_start, extent_length, output ready);
endinterface

[design/fetoc_rsp_if.sv]
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one response word.
// ----------------------------------------------------------------------------
interface fetoc_rsp_if import fetoc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [2:0]          status;
   logic [OFFSET_W-1:0] conflict_start;
   logic [OFFSET_W-1:0] conflict_length;
   logic [FILES_W-1:0]  files_in_use;
   logic [TOTAL_W-1:0]  extents_in_use;

   modport source (output valid, status, conflict_start, conflict_length, files_in_use,
                   extents_in_use, input ready);
   modport sink   (input valid, status, conflict_start, conflict_length, files_in_use,
                   extents_in_use, output ready);
endinterface

[design/fetoc_datapath.sv]
// ----------------------------------------------------------------------------
// Free extent table datapath
// File key table, per-file counts, extent memory, search pointers, result.
// ----------------------------------------------------------------------------
module fetoc_datapath import fetoc_pkg::*; #(
   parameter int MAX_FILES   = DEFAULT_MAX_FILES,
   parameter int MAX_EXTENTS = DEFAULT_MAX_EXTENTS
) (
   input  logic                clock,
   input  logic                reset,
   input  dp_cmd_type          cmd,
   output dp_status_type       stat,
   input  logic [1:0]          req_operation,
   input  logic [7:0]          req_store_index,
   input  logic [7:0]          req_dir_high,
   input  logic [7:0]          req_dir_low,
   input  logic [31:0]         req_trunk_id,
   input  logic [OFFSET_W-1:0] req_extent_start,
   input  logic [OFFSET_W-1:0] req_extent_length,
   output logic [2:0]          rsp_status,
   output logic [OFFSET_W-1:0] rsp_conflict_start,
   output logic [OFFSET_W-1:0] rsp_conflict_length,
   output logic [FILES_W-1:0]  rsp_files_in_use,
   output logic [TOTAL_W-1:0]  rsp_extents_in_use
);

   localparam int SW    = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
   localparam int CW    = $clog2(MAX_EXTENTS + 1);
   localparam int DEPTH = MAX_FILES * MAX_EXTENTS;
   localparam int AW    = $clog2(DEPTH);
   localparam int FW    = $clog2(MAX_FILES + 1);
   localparam int TW    = $clog2(DEPTH + 1);

   // Request.
   logic [1:0]          op_ff;
   logic [KEY_W-1:0]    key_ff;
   logic [OFFSET_W-1:0] start_ff;
   logic [OFFSET_W-1:0] length_ff;

   // Key scan and selected slot.
   logic [SW:0]   scan_ff;
   logic          hit_ff;
   logic [SW-1:0] hit_slot_ff;
   logic          free_ff;
   logic [SW-1:0] free_slot_ff;
   logic [SW-1:0] slot_ff;
   logic          fresh_ff;
   logic [CW-1:0] n_ff;
   logic [CW-1:0] lo_ff;
   logic [CW-1:0] hi_ff;
   logic [CW-1:0] k_ff;

   // Table state.
   logic [KEY_W-1:0] file_key_ff [MAX_FILES];
   logic             file_valid_ff [MAX_FILES];
   logic [CW-1:0]    count_ff [MAX_FILES];
   logic [FW-1:0]    claimed_ff;
   logic [TW-1:0]    total_ff;

   // Extent memory, one row of MAX_EXTENTS entries per file slot.
   logic [ENTRY_W-1:0] mem [DEPTH];
   logic [ENTRY_W-1:0] rd_ff;

   logic [2:0]          status_ff;
   logic [OFFSET_W-1:0] cs_ff;
   logic [OFFSET_W-1:0] cl_ff;
   logic [FILES_W-1:0]  files_ff;
   logic [TOTAL_W-1:0]  ext_ff;

   logic [SW-1:0]       scan_idx;
   logic [CW:0]         mid_sum;
   logic [CW-1:0]       mid;
   logic [AW-1:0]       base;
   logic [OFFSET_W-1:0] st;
   logic [OFFSET_W-1:0] ln;
   logic [OFFSET_W:0]   end_req;
   logic [OFFSET_W:0]   end_st;
   logic                rd_en;
   logic [AW-1:0]       rd_addr;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [ENTRY_W-1:0]  wr_data;
   logic                conflict;

   assign scan_idx = scan_ff[SW-1:0];
   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff} - (CW + 1)'(1);
   assign mid      = mid_sum[CW:1];
   assign base     = AW'(int'(slot_ff) * MAX_EXTENTS);
   assign st       = rd_ff[ENTRY_W-1:OFFSET_W];
   assign ln       = rd_ff[OFFSET_W-1:0];
   // Extent ends are formed one bit wider so they never wrap.
   assign end_req  = {1'b0, start_ff} + {1'b0, length_ff};
   assign end_st   = {1'b0, st} + {1'b0, ln};
   assign conflict = (cmd.code == ST_DUP) || (cmd.code == ST_OVERLAP);

   always_comb begin
      stat.op         = op_ff;
      stat.scan_done  = (scan_ff == (SW + 1)'(MAX_FILES));
      stat.hit        = hit_ff;
      stat.free_ok    = free_ff;
      stat.count_zero = (n_ff == '0);
      stat.list_full  = (n_ff >= CW'(MAX_EXTENTS));
      stat.lo_lt_hi   = (lo_ff < hi_ff);
      stat.pos_lt_n   = (lo_ff < n_ff);
      stat.k_gt_pos   = (k_ff > lo_ff);
      stat.k1_lt_n    = ({1'b0, k_ff} + (CW + 1)'(1) < {1'b0, n_ff});
      stat.e_le_st    = (end_req <= {1'b0, st});
      stat.s_ge_end   = ({1'b0, start_ff} >= end_st);
      stat.s_lt_st    = (start_ff < st);
      stat.s_eq_st    = (start_ff == st);
      stat.len_eq     = (length_ff == ln);
      stat.st_lt_e    = ({1'b0, st} < end_req);
      stat.s_lt_end   = ({1'b0, start_ff} < end_st);
   end

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = base;
      wr_en   = 1'b0;
      wr_addr = base + AW'(k_ff);
      wr_data = rd_ff;
      case (cmd.op)
         CMD_RD_FIRST: rd_en = 1'b1;
         CMD_RD_LAST: begin
            rd_en   = 1'b1;
            rd_addr = base + AW'(n_ff - CW'(1));
         end
         CMD_RD_MID: begin
            rd_en   = 1'b1;
            rd_addr = base + AW'(mid);
         end
         CMD_RD_POS: begin
            rd_en   = 1'b1;
            rd_addr = base + AW'(lo_ff);
         end
         CMD_UP_RD: begin
            rd_en   = 1'b1;
            rd_addr = base + AW'(k_ff - CW'(1));
         end
         CMD_DN_RD: begin
            rd_en   = 1'b1;
            rd_addr = base + AW'(k_ff + CW'(1));
         end
         CMD_UP_WR, CMD_DN_WR: wr_en = 1'b1;
         CMD_INS: begin
            wr_en   = 1'b1;
            wr_addr = base + AW'(lo_ff);
            wr_data = {start_ff, length_ff};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   // Request, scan, pointer, file key and result registers; all are loaded before use.
   always_ff @(posedge clock) begin
      case (cmd.op)
         CMD_LOAD: begin
            op_ff     <= req_operation;
            key_ff    <= {req_store_index, req_dir_high, req_dir_low, req_trunk_id};
            start_ff  <= req_extent_start;
            length_ff <= req_extent_length;
            scan_ff   <= '0;
            hit_ff    <= 1'b0;
            free_ff   <= 1'b0;
         end
         CMD_SCAN: begin
            // Lowest matching valid slot and lowest free slot win.
            if (file_valid_ff[scan_idx] && file_key_ff[scan_idx] == key_ff && !hit_ff) begin
               hit_ff      <= 1'b1;
               hit_slot_ff <= scan_idx;
            end
            if (!file_valid_ff[scan_idx] && !free_ff) begin
               free_ff      <= 1'b1;
               free_slot_ff <= scan_idx;
            end
            scan_ff <= scan_ff + (SW + 1)'(1);
         end
         CMD_SETUP: begin
            slot_ff  <= hit_ff ? hit_slot_ff : free_slot_ff;
            fresh_ff <= !hit_ff;
            n_ff     <= hit_ff ? count_ff[hit_slot_ff] : '0;
            hi_ff    <= hit_ff ? count_ff[hit_slot_ff] : '0;
            k_ff     <= hit_ff ? count_ff[hit_slot_ff] : '0;
            lo_ff    <= '0;
         end
         CMD_BS_STEP: begin
            if (st < start_ff) begin
               lo_ff <= mid + CW'(1);
            end else begin
               hi_ff <= mid;
            end
         end
         CMD_K_POS: k_ff <= lo_ff;
         CMD_UP_WR: k_ff <= k_ff - CW'(1);
         CMD_DN_WR: k_ff <= k_ff + CW'(1);
         CMD_INS: begin
            if (fresh_ff) begin
               file_key_ff[slot_ff] <= key_ff;
            end
         end
         default: ;
      endcase
      if (cmd.result) begin
         status_ff <= cmd.code;
         cs_ff     <= conflict ? st : '0;
         cl_ff     <= conflict ? ln : '0;
         files_ff  <= FILES_W'(claimed_ff);
         ext_ff    <= TOTAL_W'(total_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_FILES; i++) begin
            file_valid_ff[i] <= 1'b0;
            count_ff[i]      <= '0;
         end
         claimed_ff <= '0;
         total_ff   <= '0;
      end else begin
         case (cmd.op)
            CMD_INS: begin
               count_ff[slot_ff] <= n_ff + CW'(1);
               total_ff          <= total_ff + TW'(1);
               if (fresh_ff) begin
                  file_valid_ff[slot_ff] <= 1'b1;
                  claimed_ff             <= claimed_ff + FW'(1);
               end
            end
            CMD_DEL: begin
               count_ff[slot_ff] <= n_ff - CW'(1);
               total_ff          <= total_ff - TW'(1);
               if (n_ff == CW'(1)) begin
                  file_valid_ff[slot_ff] <= 1'b0;
                  claimed_ff             <= claimed_ff - FW'(1);
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_status          = status_ff;
   assign rsp_conflict_start  = cs_ff;
   assign rsp_conflict_length = cl_ff;
   assign rsp_files_in_use    = files_ff;
   assign rsp_extents_in_use  = ext_ff;

endmodule

[design/fetoc_controller.sv]
// ----------------------------------------------------------------------------
// Free extent table controller
// Sequences key scan, binary search, shifting and the response handshake.
// ----------------------------------------------------------------------------
module fetoc_controller import fetoc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output dp_cmd_type    cmd,
   input  dp_status_type stat
);

   typedef enum logic [4:0] {
      S_IDLE, S_SCAN, S_SETUP, S_DECIDE, S_EV_FIRST, S_RD_LAST, S_EV_LAST,
      S_CK_RD, S_CK_EV, S_BS_RD, S_BS_EV, S_BS_END, S_POS_EV,
      S_UP_RD, S_UP_WR, S_INS, S_DN_RD, S_DN_WR, S_DEL, S_FINISH
   } state_type;

   state_type  state_ff, state_in;
   status_type code_ff, code_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      code_in      = code_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.op       = CMD_NONE;
      cmd.result   = 1'b0;
      cmd.code     = code_ff;
      req_ready    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = CMD_LOAD;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (stat.scan_done) begin
               state_in = S_SETUP;
            end else begin
               cmd.op = CMD_SCAN;
            end
         end
         S_SETUP: begin
            cmd.op   = CMD_SETUP;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            state_in = S_FINISH;
            code_in  = ST_OK;
            case (stat.op)
               OP_CHECK: begin
                  if (stat.hit && !stat.count_zero) begin
                     cmd.op   = CMD_RD_FIRST;
                     state_in = S_EV_FIRST;
                  end
               end
               OP_INSERT: begin
                  if (!stat.hit && !stat.free_ok) begin
                     code_in = ST_FILES_FULL;
                  end else if (stat.list_full) begin
                     code_in = ST_LIST_FULL;
                  end else begin
                     state_in = S_BS_RD;
                  end
               end
               OP_DELETE: begin
                  if (stat.hit) begin
                     state_in = S_BS_RD;
                  end else begin
                     code_in = ST_NOT_FOUND;
                  end
               end
               default: ;
            endcase
         end
         S_EV_FIRST: begin
            if (stat.e_le_st) begin
               code_in  = ST_OK;
               state_in = S_FINISH;
            end else begin
               state_in = S_RD_LAST;
            end
         end
         S_RD_LAST: begin
            cmd.op   = CMD_RD_LAST;
            state_in = S_EV_LAST;
         end
         S_EV_LAST: begin
            if (stat.s_ge_end) begin
               code_in  = ST_OK;
               state_in = S_FINISH;
            end else begin
               state_in = S_CK_RD;
            end
         end
         S_CK_RD: begin
            if (stat.lo_lt_hi) begin
               cmd.op   = CMD_RD_MID;
               state_in = S_CK_EV;
            end else begin
               code_in  = ST_OK;
               state_in = S_FINISH;
            end
         end
         S_CK_EV: begin
            if (stat.s_eq_st) begin
               code_in  = stat.len_eq ? ST_DUP : ST_OVERLAP;
               state_in = S_FINISH;
            end else if (stat.s_lt_st ? stat.st_lt_e : stat.s_lt_end) begin
               code_in  = ST_OVERLAP;
               state_in = S_FINISH;
            end else begin
               cmd.op   = CMD_BS_STEP;
               state_in = S_CK_RD;
            end
         end
         S_BS_RD: begin
            if (stat.lo_lt_hi) begin
               cmd.op   = CMD_RD_MID;
               state_in = S_BS_EV;
            end else begin
               state_in = S_BS_END;
            end
         end
         S_BS_EV: begin
            cmd.op   = CMD_BS_STEP;
            state_in = S_BS_RD;
         end
         S_BS_END: begin
            if (stat.pos_lt_n) begin
               cmd.op   = CMD_RD_POS;
               state_in = S_POS_EV;
            end else if (stat.op == OP_INSERT) begin
               state_in = S_UP_RD;
            end else begin
               code_in  = ST_NOT_FOUND;
               state_in = S_FINISH;
            end
         end
         S_POS_EV: begin
            if (stat.op == OP_INSERT) begin
               if (stat.s_eq_st) begin
                  code_in  = ST_DUP;
                  state_in = S_FINISH;
               end else begin
                  state_in = S_UP_RD;
               end
            end else if (stat.s_eq_st) begin
               cmd.op   = CMD_K_POS;
               state_in = S_DN_RD;
            end else begin
               code_in  = ST_NOT_FOUND;
               state_in = S_FINISH;
            end
         end
         S_UP_RD: begin
            if (stat.k_gt_pos) begin
               cmd.op   = CMD_UP_RD;
               state_in = S_UP_WR;
            end else begin
               state_in = S_INS;
            end
         end
         S_UP_WR: begin
            cmd.op   = CMD_UP_WR;
            state_in = S_UP_RD;
         end
         S_INS: begin
            cmd.op   = CMD_INS;
            code_in  = ST_OK;
            state_in = S_FINISH;
         end
         S_DN_RD: begin
            if (stat.k1_lt_n) begin
               cmd.op   = CMD_DN_RD;
               state_in = S_DN_WR;
            end else begin
               state_in = S_DEL;
            end
         end
         S_DN_WR: begin
            cmd.op   = CMD_DN_WR;
            state_in = S_DN_RD;
         end
         S_DEL: begin
            cmd.op   = CMD_DEL;
            code_in  = ST_OK;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.result   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         code_ff      <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         code_ff      <= code_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[design/free_extent_table_overlap_check_core.sv]
// ----------------------------------------------------------------------------
// Free extent table with overlap check
// Per-file sorted free extent lists with check, insert and delete requests.
// ----------------------------------------------------------------------------
// Each request word takes one item at a time and returns exactly one response
// word. A request first scans all MAX_FILES key slots, one per cycle, then
// works on the file's row of the extent memory, which has one read and one
// write port with a registered read. A check runs a binary search over the
// row. An insert or delete runs a lower-bound search; an insert then moves
// the extents from the found position up by one place, a delete moves those
// above it down by one. The last step waits for as long as the previous
// response word is still held by the sink. The extent memory is never
// cleared: each slot's fill count bounds what is read, so the block is
// ready right after reset. A finished response waits in an output register,
// so the next request word can be taken meanwhile.
module free_extent_table_overlap_check_core import fetoc_pkg::*; #(
   parameter int MAX_FILES   = DEFAULT_MAX_FILES,
   parameter int MAX_EXTENTS = DEFAULT_MAX_EXTENTS
) (
   input logic        clock,
   input logic        reset,
   fetoc_req_if.sink  req_ch,
   fetoc_rsp_if.source rsp_ch
);

   dp_cmd_type    cmd;
   dp_status_type stat;

   // The controller owns both handshakes; the datapath owns all payload.
   fetoc_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   fetoc_datapath #(
      .MAX_FILES   (MAX_FILES),
      .MAX_EXTENTS (MAX_EXTENTS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_operation       (req_ch.operation),
      .req_store_index     (req_ch.store_index),
      .req_dir_high        (req_ch.dir_high),
      .req_dir_low         (req_ch.dir_low),
      .req_trunk_id        (req_ch.trunk_id),
      .req_extent_start    (req_ch.extent_start),
      .req_extent_length   (req_ch.extent_length),
      .rsp_status          (rsp_ch.status),
      .rsp_conflict_start  (rsp_ch.conflict_start),
      .rsp_conflict_length (rsp_ch.conflict_length),
      .rsp_files_in_use    (rsp_ch.files_in_use),
      .rsp_extents_in_use  (rsp_ch.extents_in_use)
   );

endmodule

[dv/tb_free_extent_table_overlap_check_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Free extent table testbench
// Drives check, insert, delete and unused-code request words into the extent table and
// compares every response word with a behavioral copy of the table kept here.
// ----------------------------------------------------------------------------
module tb_free_extent_table_overlap_check_core;
   import fetoc_pkg::*;

   localparam int NFILES = DEFAULT_MAX_FILES;
   localparam int NEXT   = DEFAULT_MAX_EXTENTS;
   localparam int NUM_RANDOM = 720;
   localparam longint CYCLE_LIMIT = 2000000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #6 clock = ~clock;

   fetoc_req_if req_ch ();
   fetoc_rsp_if rsp_ch ();

   free_extent_table_overlap_check_core DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  store_index;
      logic [7:0]  dir_high;
      logic [7:0]  dir_low;
      logic [31:0] trunk_id;
      logic [30:0] start;
      logic [30:0] length;
   } request_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [30:0] cstart;
      logic [30:0] clength;
      logic [4:0]  files;
      logic [10:0] extents;
   } response_type;

   // Shadow copy of the table state.
   logic [55:0] shadow_key  [NFILES];
   logic        shadow_used [NFILES];
   int          shadow_count[NFILES];
   logic [30:0] shadow_start[NFILES][NEXT];
   logic [30:0] shadow_len  [NFILES][NEXT];
   int          shadow_total;
   int          shadow_files;

   response_type expected_rsp[$];
   int           errors = 0;
   longint       cycle_count = 0;

   // Position of the first stored start that is not below s.
   function automatic int first_not_below(int slot, logic [30:0] s);
      int lo;
      int hi;
      int m;
      lo = 0;
      hi = shadow_count[slot];
      while (lo < hi) begin
         m = lo + (hi - lo) / 2;
         if (shadow_start[slot][m] < s) lo = m + 1;
         else hi = m;
      end
      return lo;
   endfunction

   // Computes the response word of one request and updates the shadow table.
   function automatic response_type apply_request(request_type r);
      response_type o;
      logic [55:0]  key;
      int           slot;
      int           n;
      int           pos;
      int           left;
      int           right;
      int           mid;
      logic         fresh;
      logic         done;
      logic [31:0]  e_req;
      logic [31:0]  e_mid;
      o = '0;
      key = {r.store_index, r.dir_high, r.dir_low, r.trunk_id};
      slot = -1;
      for (int i = NFILES - 1; i >= 0; i--)
         if (shadow_used[i] && shadow_key[i] == key) slot = i;
      o.status = ST_OK;
      if (r.op == OP_CHECK) begin
         if (slot >= 0 && shadow_count[slot] != 0) begin
            n = shadow_count[slot];
            e_req = {1'b0, r.start} + {1'b0, r.length};
            e_mid = {1'b0, shadow_start[slot][n-1]} + {1'b0, shadow_len[slot][n-1]};
            if (e_req > {1'b0, shadow_start[slot][0]} && {1'b0, r.start} < e_mid) begin
               left = 0;
               right = n - 1;
               done = 1'b0;
               while (left <= right && !done) begin
                  mid = (left + right) / 2;
                  e_mid = {1'b0, shadow_start[slot][mid]} + {1'b0, shadow_len[slot][mid]};
                  if (r.start < shadow_start[slot][mid]) begin
                     if ({1'b0, shadow_start[slot][mid]} < e_req) begin
                        o.status = ST_OVERLAP;
                        done = 1'b1;
                     end else right = mid - 1;
                  end else if (r.start == shadow_start[slot][mid]) begin
                     o.status = (r.length == shadow_len[slot][mid]) ? ST_DUP : ST_OVERLAP;
                     done = 1'b1;
                  end else begin
                     if ({1'b0, r.start} < e_mid) begin
                        o.status = ST_OVERLAP;
                        done = 1'b1;
                     end else left = mid + 1;
                  end
               end
               if (done) begin
                  o.cstart  = shadow_start[slot][mid];
                  o.clength = shadow_len[slot][mid];
               end
            end
         end
      end else if (r.op == OP_INSERT) begin
         fresh = 1'b0;
         if (slot < 0) begin
            for (int i = NFILES - 1; i >= 0; i--)
               if (!shadow_used[i]) slot = i;
            fresh = 1'b1;
         end
         if (slot < 0) o.status = ST_FILES_FULL;
         else if (!fresh && shadow_count[slot] >= NEXT) o.status = ST_LIST_FULL;
         else begin
            if (fresh) shadow_count[slot] = 0;
            n = shadow_count[slot];
            pos = first_not_below(slot, r.start);
            if (pos < n && shadow_start[slot][pos] == r.start) begin
               o.status  = ST_DUP;
               o.cstart  = shadow_start[slot][pos];
               o.clength = shadow_len[slot][pos];
            end else begin
               for (int k = n; k > pos; k--) begin
                  shadow_start[slot][k] = shadow_start[slot][k-1];
                  shadow_len[slot][k]   = shadow_len[slot][k-1];
               end
               shadow_start[slot][pos] = r.start;
               shadow_len[slot][pos]   = r.length;
               if (fresh) begin
                  shadow_used[slot] = 1'b1;
                  shadow_key[slot]  = key;
                  shadow_files++;
               end
               shadow_count[slot] = n + 1;
               shadow_total++;
            end
         end
      end else if (r.op == OP_DELETE) begin
         if (slot < 0) o.status = ST_NOT_FOUND;
         else begin
            n = shadow_count[slot];
            pos = first_not_below(slot, r.start);
            if (pos >= n || shadow_start[slot][pos] != r.start) o.status = ST_NOT_FOUND;
            else begin
               for (int k = pos; k + 1 < n; k++) begin
                  shadow_start[slot][k] = shadow_start[slot][k+1];
                  shadow_len[slot][k]   = shadow_len[slot][k+1];
               end
               shadow_count[slot] = n - 1;
               shadow_total--;
               if (n == 1) begin
                  shadow_used[slot] = 1'b0;
                  shadow_files--;
               end
            end
         end
      end
      o.files   = shadow_files[4:0];
      o.extents = shadow_total[10:0];
      return o;
   endfunction

   // Directed rows. When fixed is set, the typed-in response must also match
   // the shadow table's answer, which guards both sides.
   typedef struct {
      request_type  req;
      logic         fixed;
      response_type rsp;
   } row_type;

   function automatic request_type mk(logic [1:0] op, logic [7:0] si, logic [31:0] tid,
                                      logic [30:0] s, logic [30:0] l);
      request_type r;
      r = '{op, si, 8'h00, 8'h00, tid, s, l};
      return r;
   endfunction

   row_type directed[$];

   task automatic build_directed();
      // Empty table: check is clean, delete finds nothing.
      directed.push_back('{mk(OP_CHECK, 8'd0, 32'd0, 31'd0, 31'd0), 1'b1,
                           '{ST_OK, 31'd0, 31'd0, 5'd0, 11'd0}});
      directed.push_back('{mk(OP_DELETE, 8'hFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 31'd5), 1'b1,
                           '{ST_NOT_FOUND, 31'd0, 31'd0, 5'd0, 11'd0}});
      directed.push_back('{mk(OP_INSERT, 8'd1, 32'd7, 31'd100, 31'd50), 1'b1,
                           '{ST_OK, 31'd0, 31'd0, 5'd1, 11'd1}});
      // Equal start is refused and the stored extent is returned.
      directed.push_back('{mk(OP_INSERT, 8'd1, 32'd7, 31'd100, 31'd9), 1'b1,
                           '{ST_DUP, 31'd100, 31'd50, 5'd1, 11'd1}});
      directed.push_back('{mk(OP_CHECK, 8'd1, 32'd7, 31'd100, 31'd50), 1'b1,
                           '{ST_DUP, 31'd100, 31'd50, 5'd1, 11'd1}});
      directed.push_back('{mk(OP_CHECK, 8'd1, 32'd7, 31'd100, 31'd1), 1'b1,
                           '{ST_OVERLAP, 31'd100, 31'd50, 5'd1, 11'd1}});
      directed.push_back('{mk(OP_CHECK, 8'd1, 32'd7, 31'd90, 31'd10), 1'b1,
                           '{ST_OK, 31'd0, 31'd0, 5'd1, 11'd1}});
      directed.push_back('{mk(OP_CHECK, 8'd1, 32'd7, 31'd149, 31'd1), 0, '0});
      directed.push_back('{mk(OP_INSERT, 8'd1, 32'd7, 31'h7FFF_FFFF, 31'h7FFF_FFFF), 0, '0});
      // Ends near the top never wrap.
      directed.push_back('{mk(OP_CHECK, 8'd1, 32'd7, 31'h7FFF_FFF0, 31'h7FFF_FFFF), 0, '0});
      directed.push_back('{mk(OP_INSERT, 8'd1, 32'd7, 31'd0, 31'd0), 0, '0});
      directed.push_back('{mk(OP_INSERT, 8'd1, 32'd7, 31'd300, 31'd10), 0, '0});
      directed.push_back('{mk(OP_CHECK, 8'd1, 32'd7, 31'd120, 31'd1000), 0, '0});
      // Delete ignores the length.
      directed.push_back('{mk(OP_DELETE, 8'd1, 32'd7, 31'd300, 31'd1), 0, '0});
      directed.push_back('{mk(OP_DELETE, 8'd1, 32'd7, 31'd301, 31'd10), 0, '0});
      // Unused operation code: no effect.
      directed.push_back('{mk(2'd3, 8'd1, 32'd7, 31'd100, 31'd50), 0, '0});
      directed.push_back('{mk(OP_INSERT, 8'd2, 32'd7, 31'd100, 31'd50), 0, '0});
      directed.push_back('{mk(OP_DELETE, 8'd2, 32'd7, 31'd100, 31'd0), 0, '0});
   endtask

   // Called at a falling edge; returns at the falling edge after the accept
   // with valid still high, so the next word can follow with no gap.
   task automatic send_word(request_type r);
      int gap;
      gap = $urandom_range(0, 7);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.operation     <= r.op;
      req_ch.store_index   <= r.store_index;
      req_ch.dir_high      <= r.dir_high;
      req_ch.dir_low       <= r.dir_low;
      req_ch.trunk_id      <= r.trunk_id;
      req_ch.extent_start  <= r.start;
      req_ch.extent_length <= r.length;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      expected_rsp.push_back(apply_request(r));
      @(negedge clock);
   endtask

   // Random request aimed at a small set of keys so lists grow and shrink.
   function automatic request_type random_word(int phase);
      request_type r;
      int          u;
      r.store_index = 8'($urandom_range(0, 3));
      r.dir_high    = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'd0;
      r.dir_low     = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'hA5;
      r.trunk_id    = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 4));
      // Phase 1 spreads keys wide to fill the file table.
      if (phase == 1) r.trunk_id = 32'($urandom_range(0, 40));
      u = $urandom_range(0, 99);
      if (u < 45)      r.op = OP_INSERT;
      else if (u < 75) r.op = OP_CHECK;
      else if (u < 97) r.op = OP_DELETE;
      else             r.op = 2'd3;
      if ($urandom_range(0, 15) == 0) begin
         r.start  = 31'($urandom);
         r.length = 31'($urandom);
      end else begin
         r.start  = 31'($urandom_range(0, 63) * 16);
         r.length = 31'($urandom_range(0, 40));
      end
      // Deletes lean on the known low starts to actually hit.
      if (r.op == OP_DELETE && phase == 0) r.start = 31'($urandom_range(0, 63) * 16);
      return r;
   endfunction

   // Response side: a random number of idle cycles before each word.
   initial begin
      int gap;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         gap = $urandom_range(0, 7);
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_ch.valid && rsp_ch.ready)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      response_type got;
      response_type exp_r;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = '{rsp_ch.status, rsp_ch.conflict_start, rsp_ch.conflict_length,
                 rsp_ch.files_in_use, rsp_ch.extents_in_use};
         if (expected_rsp.size() == 0) begin
            $display("%0t unexpected response word: expected none, actual %p", $time, got);
            errors++;
         end else begin
            exp_r = expected_rsp.pop_front();
            if (got !== exp_r) begin
               $display("%0t response mismatch: expected %p, actual %p", $time, exp_r, got);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      response_type want;
      req_ch.valid = 1'b0;
      req_ch.operation = '0;
      req_ch.store_index = '0;
      req_ch.dir_high = '0;
      req_ch.dir_low = '0;
      req_ch.trunk_id = '0;
      req_ch.extent_start = '0;
      req_ch.extent_length = '0;
      for (int i = 0; i < NFILES; i++) begin
         shadow_used[i] = 1'b0;
         shadow_count[i] = 0;
      end
      shadow_total = 0;
      shadow_files = 0;
      build_directed();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         send_word(directed[i].req);
         want = expected_rsp[$];
         if (directed[i].fixed && want !== directed[i].rsp) begin
            $display("%0t table row %0d: expected %p, actual %p", $time, i,
                     directed[i].rsp, want);
            errors++;
         end
      end
      // Mostly narrow keys; a middle stretch spreads keys to hit a full file
      // table, and one key gets filled to its list limit.
      for (int n = 0; n < NUM_RANDOM; n++)
         send_word(random_word((n >= 300 && n < 420) ? 1 : 0));
      for (int n = 0; n < NEXT + 2; n++)
         send_word(mk(OP_INSERT, 8'd9, 32'd9, 31'(n * 4), 31'd2));
      send_word(mk(OP_CHECK, 8'd9, 32'd9, 31'd41, 31'd30));
      send_word(mk(OP_DELETE, 8'd9, 32'd9, 31'd0, 31'd2));
      req_ch.valid <= 1'b0;

      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0 && expected_rsp.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule

[free_extent_table_overlap_check_core.f]
design/fetoc_pkg.sv
design/fetoc_req_if.sv
design/fetoc_rsp_if.sv
design/fetoc_datapath.sv
design/fetoc_controller.sv
design/free_extent_table_overlap_check_core.sv
dv/tb_free_extent_table_overlap_check_core.sv
